// ----- rtl/lcdnw_pkg.sv -----
// lcdnw_pkg: shared types and constants for the LCD I2C nibble writer.
// No dependencies; used by every module in rtl/.
package lcdnw_pkg;

  typedef enum logic [2:0] {
    KIND_CMD    = 3'd0,
    KIND_DATA   = 3'd1,
    KIND_NUMBER = 3'd2,
    KIND_CURSOR = 3'd3,
    KIND_INIT   = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_SINGLE,
    F_NUM,
    F_INIT
  } fstate_t;

  typedef enum logic [2:0] {
    PH_ADDR,
    PH_HI_ON,
    PH_HI_OFF,
    PH_LO_ON,
    PH_LO_OFF
  } phase_t;

  // one LCD byte waiting to be expanded into a bus transfer
  typedef struct packed {
    logic [7:0] lcd_byte;
    logic       is_data;
    logic       last;
  } lcd_entry_t;

  localparam logic [7:0]  ADDR_RESET  = 8'h4E;
  localparam logic [7:0]  BL_EN_CMD   = 8'h0C;
  localparam logic [7:0]  BL_CMD      = 8'h08;
  localparam logic [7:0]  BL_EN_DAT   = 8'h0D;
  localparam logic [7:0]  BL_DAT      = 8'h09;
  localparam logic [7:0]  NIBBLE_MASK = 8'hF0;
  localparam logic [7:0]  LINE0_BASE  = 8'h80;
  localparam logic [7:0]  LINE1_BASE  = 8'hC0;
  localparam logic [7:0]  ASCII_ZERO  = 8'd48;
  localparam logic [13:0] NUM_LIMIT   = 14'd10000;
  localparam logic [2:0]  NUM_STEP_LAST  = 3'd3;
  localparam logic [2:0]  INIT_STEP_LAST = 3'd4;

  function automatic logic [7:0] init_cmd(input logic [2:0] step);
    logic [7:0] c;
    case (step)
      3'd0:    c = 8'h02;
      3'd1:    c = 8'h28;
      3'd2:    c = 8'h0C;
      3'd3:    c = 8'h06;
      3'd4:    c = 8'h01;
      default: c = 8'h01;
    endcase
    return c;
  endfunction

  // decimal place weight, most significant digit first
  function automatic logic [13:0] place_weight(input logic [2:0] step);
    logic [13:0] w;
    case (step)
      3'd0:    w = 14'd1000;
      3'd1:    w = 14'd100;
      3'd2:    w = 14'd10;
      3'd3:    w = 14'd1;
      default: w = 14'd1;
    endcase
    return w;
  endfunction

endpackage

// ----- rtl/lcdnw_front.sv -----
// lcdnw_front: accepts display requests and breaks them into LCD bytes.
// Depends on lcdnw_pkg; feeds lcdnw_fifo.
module lcdnw_front (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_push,
  output logic                    in_full,
  input  logic [2:0]              in_kind,
  input  logic [7:0]              in_value,
  input  logic [13:0]             in_number,
  input  logic [5:0]              in_column,
  input  logic                    in_row,
  input  logic                    q_full,
  output logic                    q_push,
  output lcdnw_pkg::lcd_entry_t   q_entry
);

  lcdnw_pkg::fstate_t state_r, state_nxt;
  logic [7:0]  byte_r,  byte_nxt;
  logic        data_r,  data_nxt;
  logic [13:0] rem_r,   rem_nxt;
  logic [2:0]  step_r,  step_nxt;

  logic        accept, emit, done;
  logic [3:0]  digit;
  logic [13:0] sub;
  logic [13:0] weight;
  lcdnw_pkg::kind_t kind;

  assign kind   = lcdnw_pkg::kind_t'(in_kind);
  assign emit   = (state_r != lcdnw_pkg::F_IDLE) && !q_full;
  assign done   = emit && q_entry.last;
  assign in_full = (state_r != lcdnw_pkg::F_IDLE) && !done;
  assign accept = in_push && !in_full;
  assign q_push = emit;
  assign weight = lcdnw_pkg::place_weight(step_r);

  // digit of the current place: largest k with k*weight <= rem
  always_comb begin
    digit = 4'd0;
    sub   = 14'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem_r >= 14'(weight * 14'(k))) begin
        digit = 4'(k);
        sub   = 14'(weight * 14'(k));
      end
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    if (accept) begin
      case (kind)
        lcdnw_pkg::KIND_CMD,
        lcdnw_pkg::KIND_DATA,
        lcdnw_pkg::KIND_CURSOR: state_nxt = lcdnw_pkg::F_SINGLE;
        lcdnw_pkg::KIND_NUMBER: state_nxt = (in_number < lcdnw_pkg::NUM_LIMIT) ?
                                            lcdnw_pkg::F_NUM : lcdnw_pkg::F_IDLE;
        lcdnw_pkg::KIND_INIT:   state_nxt = lcdnw_pkg::F_INIT;
        default:                state_nxt = lcdnw_pkg::F_IDLE;
      endcase
    end else if (done) begin
      state_nxt = lcdnw_pkg::F_IDLE;
    end
  end

  // outputs
  always_comb begin
    q_entry = '0;
    case (state_r)
      lcdnw_pkg::F_SINGLE: begin
        q_entry.lcd_byte = byte_r;
        q_entry.is_data  = data_r;
        q_entry.last     = 1'b1;
      end
      lcdnw_pkg::F_NUM: begin
        q_entry.lcd_byte = lcdnw_pkg::ASCII_ZERO + {4'd0, digit};
        q_entry.is_data  = 1'b1;
        q_entry.last     = (step_r == lcdnw_pkg::NUM_STEP_LAST);
      end
      lcdnw_pkg::F_INIT: begin
        q_entry.lcd_byte = lcdnw_pkg::init_cmd(step_r);
        q_entry.is_data  = 1'b0;
        q_entry.last     = (step_r == lcdnw_pkg::INIT_STEP_LAST);
      end
      default: q_entry = '0;
    endcase
  end

  // request payload
  always_comb begin
    byte_nxt = byte_r;
    data_nxt = data_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    if (accept) begin
      byte_nxt = in_value;
      if (kind == lcdnw_pkg::KIND_CURSOR) begin
        byte_nxt = (in_row ? lcdnw_pkg::LINE1_BASE : lcdnw_pkg::LINE0_BASE)
                   + {2'b00, in_column};
      end
      data_nxt = (kind == lcdnw_pkg::KIND_DATA);
      rem_nxt  = in_number;
      if (kind == lcdnw_pkg::KIND_NUMBER) begin
        step_nxt = (in_number >= 14'd1000) ? 3'd0 :
                   (in_number >= 14'd100)  ? 3'd1 :
                   (in_number >= 14'd10)   ? 3'd2 : 3'd3;
      end else begin
        step_nxt = 3'd0;
      end
    end else if (emit && !q_entry.last) begin
      step_nxt = step_r + 3'd1;
      rem_nxt  = rem_r - sub;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lcdnw_pkg::F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    byte_r <= byte_nxt;
    data_r <= data_nxt;
    rem_r  <= rem_nxt;
    step_r <= step_nxt;
  end

endmodule

// ----- rtl/lcdnw_fifo.sv -----
// lcdnw_fifo: short queue of LCD bytes between front and back.
// Depends on lcdnw_pkg for the entry type.
module lcdnw_fifo #(
  parameter int DEPTH = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  lcdnw_pkg::lcd_entry_t wr_entry,
  output logic                  full,
  input  logic                  pop,
  output lcdnw_pkg::lcd_entry_t head,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] PTR_MAX = PW'(DEPTH - 1);
  localparam logic [CW-1:0] CNT_MAX = CW'(DEPTH);

  lcdnw_pkg::lcd_entry_t mem [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          do_push, do_pop;

  assign full    = (count_r == CNT_MAX);
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_MAX) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_MAX) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wr_entry;
    end
  end

endmodule

// ----- rtl/lcdnw_back.sv -----
// lcdnw_back: expands each LCD byte into the five-byte I2C transfer.
// Depends on lcdnw_pkg; drains lcdnw_fifo and drives the result register.
module lcdnw_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [7:0]            slave_address,
  input  logic                  q_empty,
  input  lcdnw_pkg::lcd_entry_t q_head,
  output logic                  q_pop,
  output logic                  out_empty,
  input  logic                  out_pop,
  output logic [7:0]            out_bus_byte,
  output logic                  out_start_before,
  output logic                  out_stop_after,
  output logic                  out_last
);

  lcdnw_pkg::phase_t phase_r, phase_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r,  byte_nxt;
  logic       start_r, start_nxt;
  logic       stop_r,  stop_nxt;
  logic       last_r,  last_nxt;
  logic       adv;
  logic [7:0] hi, lo, on_bits, off_bits;

  assign adv      = !q_empty && (!valid_r || out_pop);
  assign hi       = q_head.lcd_byte & lcdnw_pkg::NIBBLE_MASK;
  assign lo       = {q_head.lcd_byte[3:0], 4'h0};
  assign on_bits  = q_head.is_data ? lcdnw_pkg::BL_EN_DAT : lcdnw_pkg::BL_EN_CMD;
  assign off_bits = q_head.is_data ? lcdnw_pkg::BL_DAT    : lcdnw_pkg::BL_CMD;

  // next state
  always_comb begin
    phase_nxt = phase_r;
    if (adv) begin
      case (phase_r)
        lcdnw_pkg::PH_ADDR:   phase_nxt = lcdnw_pkg::PH_HI_ON;
        lcdnw_pkg::PH_HI_ON:  phase_nxt = lcdnw_pkg::PH_HI_OFF;
        lcdnw_pkg::PH_HI_OFF: phase_nxt = lcdnw_pkg::PH_LO_ON;
        lcdnw_pkg::PH_LO_ON:  phase_nxt = lcdnw_pkg::PH_LO_OFF;
        default:              phase_nxt = lcdnw_pkg::PH_ADDR;
      endcase
    end
  end

  // outputs
  always_comb begin
    q_pop     = adv && (phase_r == lcdnw_pkg::PH_LO_OFF);
    valid_nxt = adv ? 1'b1 : (out_pop ? 1'b0 : valid_r);
    byte_nxt  = byte_r;
    start_nxt = start_r;
    stop_nxt  = stop_r;
    last_nxt  = last_r;
    if (adv) begin
      start_nxt = 1'b0;
      stop_nxt  = 1'b0;
      last_nxt  = 1'b0;
      case (phase_r)
        lcdnw_pkg::PH_ADDR: begin
          byte_nxt  = slave_address;
          start_nxt = 1'b1;
        end
        lcdnw_pkg::PH_HI_ON:  byte_nxt = hi | on_bits;
        lcdnw_pkg::PH_HI_OFF: byte_nxt = hi | off_bits;
        lcdnw_pkg::PH_LO_ON:  byte_nxt = lo | on_bits;
        default: begin
          byte_nxt = lo | off_bits;
          stop_nxt = 1'b1;
          last_nxt = q_head.last;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= lcdnw_pkg::PH_ADDR;
      valid_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      valid_r <= valid_nxt;
    end
    byte_r  <= byte_nxt;
    start_r <= start_nxt;
    stop_r  <= stop_nxt;
    last_r  <= last_nxt;
  end

  assign out_empty        = !valid_r;
  assign out_bus_byte     = byte_r;
  assign out_start_before = start_r;
  assign out_stop_after   = stop_r;
  assign out_last         = last_r;

endmodule

// ----- rtl/lcd_i2c_nibble_writer.sv -----
// lcd_i2c_nibble_writer: top level, display requests in, I2C bus bytes out.
// Depends on lcdnw_pkg, lcdnw_front, lcdnw_fifo and lcdnw_back.
//
//   channel   handshake            payload
//   in_       in_push / in_full    kind, value, number, column, row
//   out_      out_pop / out_empty  bus_byte, start_before, stop_after, last
//   cfg_      cfg_valid/cfg_ready  data (slave address)
//
// The back end emits one bus byte per cycle while not starved or stalled:
// 5 per LCD byte, so a request yields 5 (command, character, cursor), 5 to
// 20 (number) or 25 (init) bytes. The front end fills a QDEPTH-entry queue
// of LCD bytes, one per cycle unless full, and takes the next request once
// its last LCD byte is queued. Invalid kinds and numbers of 10000 or more are
// dropped. Synchronous active-low reset empties the queue, output register
// and sets the slave address to 0x4E. Either side stalls without loss.
module lcd_i2c_nibble_writer #(
  parameter int QDEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [2:0]  in_kind,
  input  logic [7:0]  in_value,
  input  logic [13:0] in_number,
  input  logic [5:0]  in_column,
  input  logic        in_row,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_bus_byte,
  output logic        out_start_before,
  output logic        out_stop_after,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  logic [7:0] slave_addr_r, slave_addr_nxt;
  logic       q_full, q_push, q_pop, q_empty;
  lcdnw_pkg::lcd_entry_t q_wr, q_head;

  assign cfg_ready      = 1'b1;
  assign slave_addr_nxt = (cfg_valid && cfg_ready) ? cfg_data : slave_addr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slave_addr_r <= lcdnw_pkg::ADDR_RESET;
    end else begin
      slave_addr_r <= slave_addr_nxt;
    end
  end

  lcdnw_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_kind   (in_kind),
    .in_value  (in_value),
    .in_number (in_number),
    .in_column (in_column),
    .in_row    (in_row),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_entry   (q_wr)
  );

  lcdnw_fifo #(
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .wr_entry (q_wr),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  lcdnw_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .slave_address    (slave_addr_r),
    .q_empty          (q_empty),
    .q_head           (q_head),
    .q_pop            (q_pop),
    .out_empty        (out_empty),
    .out_pop          (out_pop),
    .out_bus_byte     (out_bus_byte),
    .out_start_before (out_start_before),
    .out_stop_after   (out_stop_after),
    .out_last         (out_last)
  );

  a_start_stop_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !(out_start_before && out_stop_after))
    else $error("start and stop on the same bus byte");

  a_start_is_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_start_before) |-> (out_bus_byte == slave_addr_r))
    else $error("start byte is not the slave address");

  a_last_ends_transfer: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_last) |-> out_stop_after)
    else $error("last byte does not close a transfer");

  a_pop_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && out_start_before) |=> (!out_empty |-> !out_start_before))
    else $error("address byte not followed by a nibble byte");

endmodule
